// File: rtl/tll_pkg.sv
package tll_pkg;

    localparam int KW_COUNT    = 12;
    localparam int KW_TEXT_LEN = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_DELIM   = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    localparam logic [1:0] CAUSE_NONE        = 2'd0;
    localparam logic [1:0] CAUSE_DIGIT_ALPHA = 2'd1;
    localparam logic [1:0] CAUSE_BAD_BYTE    = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;

    localparam logic [5:0]  LEN_MAX  = 6'd63;
    localparam logic [15:0] LINE_MAX = 16'hffff;

    // sorted keyword table, text right-justified
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd2, 4'd4, 4'd3, 4'd8, 4'd2, 4'd3, 4'd4, 4'd4, 4'd6, 4'd5, 4'd5
    };
    localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        64'("case"), 64'("do"), 64'("else"), 64'("for"), 64'("function"), 64'("if"),
        64'("int"), 64'("main"), 64'("read"), 64'("switch"), 64'("while"), 64'("write")
    };

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] kw_index;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [5:0] length;
        logic [1:0] cause;
    } lex_tok_t;

    typedef struct packed {
        logic        two;
        lex_tok_t    t0;
        lex_tok_t    t1;
        logic [15:0] line;
    } lex_entry_t;

    typedef struct packed {
        logic       valid;
        lex_entry_t entry;
    } lex_push_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } lex_q_stat_t;

    function automatic logic [7:0] kw_char(input int k, input int i);
        int sh;
        sh = 8 * (int'(KW_LEN[k]) - 1 - i);
        if (i < int'(KW_LEN[k]))
        begin
            kw_char = KW_TEXT[k][sh +: 8];
        end
        else
        begin
            kw_char = 8'h00;
        end
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        is_upper = (c >= 8'h41) && (c <= 8'h5a);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = is_upper(c) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = is_upper(c) ? (c + 8'd32) : c;
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        is_single = (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) || (c == 8'h28) ||
                    (c == 8'h29) || (c == 8'h7b) || (c == 8'h7d) || (c == 8'h3b) ||
                    (c == 8'h2c) || (c == 8'h3a) || (c == 8'h26) || (c == 8'h27);
    endfunction

    function automatic logic is_double(input logic [7:0] c);
        is_double = (c == 8'h3e) || (c == 8'h3c) || (c == 8'h3d) || (c == 8'h21);
    endfunction

    function automatic lex_tok_t make_tok(input logic [2:0] kind, input logic [3:0] kw,
                                          input logic [7:0] c1, input logic [7:0] c2,
                                          input logic [5:0] len, input logic [1:0] cause);
        make_tok.kind        = kind;
        make_tok.kw_index    = kw;
        make_tok.first_char  = c1;
        make_tok.second_char = c2;
        make_tok.length      = len;
        make_tok.cause       = cause;
    endfunction

endpackage

// File: rtl/lex_ifs.sv
interface lex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface lex_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [3:0]  keyword_index;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [5:0]  token_length;
    logic [15:0] line_number;
    logic [1:0]  error_cause;
    logic        last_of_item;

    modport source (output valid, output token_kind, output keyword_index,
                    output first_char, output second_char, output token_length,
                    output line_number, output error_cause, output last_of_item,
                    input ready);
    modport sink (input valid, input token_kind, input keyword_index,
                  input first_char, input second_char, input token_length,
                  input line_number, input error_cause, input last_of_item,
                  output ready);
endinterface

// File: rtl/toy_language_lexer_top.sv
// Streaming lexer for the small test language.
// chars: one source byte per transfer, or end_of_input to flush the pending
//   token and restart line counting at 1.
// tokens: one descriptor per transfer; last_of_item marks the final token
//   caused by an input transfer (an item yields zero, one or two tokens).
// Throughput: one byte per cycle while the queue is not full. An item that
//   yields two tokens occupies the output twice, one token at a time; the two-entry
//   queue between the scanner and the output stage absorbs this.
// Path: a token reaches tokens through a queue entry and then the output
//   register after the transfer of the byte that completes it.
// Reset: scanner idle, line counter 1, queue empty, tokens.valid low.
// Stall: while tokens.ready is low the output holds; the queue fills and
//   chars.ready drops when it is full, resuming as soon as an entry drains.
module toy_language_lexer_top #(
    parameter int KEYWORD_MAX_LEN = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    lex_char_if.sink    chars,
    lex_token_if.source tokens
);

    tll_pkg::lex_push_t   push;
    tll_pkg::lex_entry_t  head;
    tll_pkg::lex_q_stat_t q_stat;
    logic                 pop;

    tll_front #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .q_stat (q_stat),
        .push   (push)
    );

    tll_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (q_stat)
    );

    tll_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

// File: rtl/tll_front.sv
module tll_front #(
    parameter int KEYWORD_MAX_LEN = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lex_char_if.sink             chars,
    input  tll_pkg::lex_q_stat_t q_stat,
    output tll_pkg::lex_push_t   push
);

    localparam int IW = $clog2(KEYWORD_MAX_LEN);

    typedef enum logic [8:0] {
        MODE_IDLE    = 9'b000000001,
        MODE_IDENT   = 9'b000000010,
        MODE_DIGIT1  = 9'b000000100,
        MODE_NUMBER  = 9'b000001000,
        MODE_DIGERR  = 9'b000010000,
        MODE_DOUBLE  = 9'b000100000,
        MODE_SLASH   = 9'b001000000,
        MODE_COMMENT = 9'b010000000,
        MODE_CSTAR   = 9'b100000000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [5:0]  count_reg, count_next;
    logic        too_long_reg, too_long_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] line_reg, line_next;
    logic [7:0]  letters_reg [KEYWORD_MAX_LEN];

    logic          letter_we;
    logic [IW-1:0] letter_idx;
    logic [7:0]    letter_val;

    logic             xfer;
    logic [7:0]       c;
    logic [7:0]       cc;
    logic             used;
    logic             t0v, t1v;
    tll_pkg::lex_tok_t t0, t1, start_tok, word_tok;
    logic             start_emit;
    logic [5:0]       count_inc;

    logic       kw_hit;
    logic [3:0] kw_idx;

    assign xfer        = chars.valid && chars.ready;
    assign chars.ready = !q_stat.full;
    assign c           = chars.char_code;
    assign cc          = chars.end_of_input ? tll_pkg::CH_SPACE : chars.char_code;
    assign count_inc   = (count_reg < tll_pkg::LEN_MAX) ? (count_reg + 6'd1) : count_reg;

    // parallel match of the held word against the keyword table
    always_comb
    begin
        logic same;
        logic word_ok;
        kw_hit  = 1'b0;
        kw_idx  = 4'd0;
        word_ok = !too_long_reg && (count_reg <= 6'(KEYWORD_MAX_LEN));
        for (int k = tll_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            same = (count_reg == 6'(tll_pkg::KW_LEN[k]));
            for (int i = 0; i < tll_pkg::KW_TEXT_LEN; i++)
            begin
                if ((i < int'(tll_pkg::KW_LEN[k])) &&
                    (letters_reg[i] != tll_pkg::kw_char(k, i)))
                begin
                    same = 1'b0;
                end
            end
            if (same && word_ok)
            begin
                kw_hit = 1'b1;
                kw_idx = 4'(k);
            end
        end
    end

    assign word_tok = tll_pkg::make_tok(kw_hit ? tll_pkg::KIND_KEYWORD : tll_pkg::KIND_IDENT,
                                        kw_idx, held_reg, 8'h00, count_reg,
                                        tll_pkg::CAUSE_NONE);

    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        too_long_next = too_long_reg;
        held_next     = held_reg;
        line_next     = line_reg;
        letter_we     = 1'b0;
        letter_idx    = count_reg[IW-1:0];
        letter_val    = tll_pkg::fold(c);
        used          = 1'b0;
        t0v           = 1'b0;
        t0            = '0;
        t1v           = 1'b0;
        t1            = '0;
        start_emit    = 1'b0;
        start_tok     = '0;

        case (mode_reg)
            MODE_IDLE:
            begin
                used = 1'b0;
            end
            MODE_IDENT:
            begin
                if (tll_pkg::is_alpha(cc) || tll_pkg::is_digit(cc))
                begin
                    if (count_reg < 6'(KEYWORD_MAX_LEN))
                    begin
                        letter_we = 1'b1;
                    end
                    else
                    begin
                        too_long_next = 1'b1;
                    end
                    count_next = count_inc;
                    used       = 1'b1;
                end
                else
                begin
                    t0v       = 1'b1;
                    t0        = word_tok;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_DIGIT1:
            begin
                if (tll_pkg::is_alpha(cc))
                begin
                    count_next = count_inc;
                    mode_next  = MODE_DIGERR;
                    used       = 1'b1;
                end
                else if (tll_pkg::is_digit(cc))
                begin
                    count_next = count_inc;
                    mode_next  = MODE_NUMBER;
                    used       = 1'b1;
                end
                else
                begin
                    t0v       = 1'b1;
                    t0        = tll_pkg::make_tok(tll_pkg::KIND_NUMBER, 4'd0, held_reg, 8'h00,
                                                  count_reg, tll_pkg::CAUSE_NONE);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUMBER:
            begin
                if (tll_pkg::is_digit(cc))
                begin
                    count_next = count_inc;
                    used       = 1'b1;
                end
                else
                begin
                    t0v       = 1'b1;
                    t0        = tll_pkg::make_tok(tll_pkg::KIND_NUMBER, 4'd0, held_reg, 8'h00,
                                                  count_reg, tll_pkg::CAUSE_NONE);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_DIGERR:
            begin
                if (tll_pkg::is_alpha(cc))
                begin
                    count_next = count_inc;
                    used       = 1'b1;
                end
                else
                begin
                    t0v       = 1'b1;
                    t0        = tll_pkg::make_tok(tll_pkg::KIND_ERROR, 4'd0, held_reg, 8'h00,
                                                  count_reg, tll_pkg::CAUSE_DIGIT_ALPHA);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_DOUBLE:
            begin
                t0v       = 1'b1;
                mode_next = MODE_IDLE;
                if (cc == tll_pkg::CH_EQ)
                begin
                    t0   = tll_pkg::make_tok(tll_pkg::KIND_DELIM, 4'd0, held_reg,
                                             tll_pkg::CH_EQ, 6'd2, tll_pkg::CAUSE_NONE);
                    used = 1'b1;
                end
                else
                begin
                    t0 = tll_pkg::make_tok(tll_pkg::KIND_DELIM, 4'd0, held_reg, 8'h00,
                                           6'd1, tll_pkg::CAUSE_NONE);
                end
            end
            MODE_SLASH:
            begin
                if (cc == tll_pkg::CH_STAR)
                begin
                    mode_next = MODE_COMMENT;
                    used      = 1'b1;
                end
                else
                begin
                    t0v       = 1'b1;
                    t0        = tll_pkg::make_tok(tll_pkg::KIND_DELIM, 4'd0, tll_pkg::CH_SLASH,
                                                  8'h00, 6'd1, tll_pkg::CAUSE_NONE);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_COMMENT:
            begin
                if (cc == tll_pkg::CH_STAR)
                begin
                    mode_next = MODE_CSTAR;
                end
                used = 1'b1;
            end
            MODE_CSTAR:
            begin
                if (cc == tll_pkg::CH_SLASH)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (cc != tll_pkg::CH_STAR)
                begin
                    mode_next = MODE_COMMENT;
                end
                used = 1'b1;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (chars.end_of_input)
        begin
            mode_next     = MODE_IDLE;
            count_next    = 6'd0;
            too_long_next = 1'b0;
            line_next     = 16'd1;
        end
        else if (!used)
        begin
            count_next    = 6'd1;
            held_next     = c;
            too_long_next = 1'b0;
            if ((c == tll_pkg::CH_SPACE) || (c == tll_pkg::CH_TAB))
            begin
                count_next = 6'd0;
            end
            else if (c == tll_pkg::CH_NL)
            begin
                count_next = 6'd0;
                if (line_reg < tll_pkg::LINE_MAX)
                begin
                    line_next = line_reg + 16'd1;
                end
            end
            else if (tll_pkg::is_alpha(c))
            begin
                letter_we  = 1'b1;
                letter_idx = '0;
                mode_next  = MODE_IDENT;
            end
            else if (tll_pkg::is_digit(c))
            begin
                mode_next = MODE_DIGIT1;
            end
            else if (tll_pkg::is_single(c))
            begin
                start_emit = 1'b1;
                start_tok  = tll_pkg::make_tok(tll_pkg::KIND_DELIM, 4'd0, c, 8'h00, 6'd1,
                                               tll_pkg::CAUSE_NONE);
            end
            else if (tll_pkg::is_double(c))
            begin
                mode_next = MODE_DOUBLE;
            end
            else if (c == tll_pkg::CH_SLASH)
            begin
                mode_next = MODE_SLASH;
            end
            else
            begin
                start_emit = 1'b1;
                start_tok  = tll_pkg::make_tok(tll_pkg::KIND_ERROR, 4'd0, c, 8'h00, 6'd1,
                                               tll_pkg::CAUSE_BAD_BYTE);
            end

            if (start_emit)
            begin
                if (t0v)
                begin
                    t1v = 1'b1;
                    t1  = start_tok;
                end
                else
                begin
                    t0v = 1'b1;
                    t0  = start_tok;
                end
            end
        end
    end

    assign push.valid       = xfer && t0v;
    assign push.entry.two   = t1v;
    assign push.entry.t0    = t0;
    assign push.entry.t1    = t1;
    assign push.entry.line  = line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            count_reg    <= 6'd0;
            too_long_reg <= 1'b0;
            held_reg     <= 8'h00;
            line_reg     <= 16'd1;
        end
        else if (xfer)
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            too_long_reg <= too_long_next;
            held_reg     <= held_next;
            line_reg     <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer && letter_we)
        begin
            letters_reg[letter_idx] <= letter_val;
        end
    end

endmodule

// File: rtl/tll_queue.sv
module tll_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tll_pkg::lex_push_t   push,
    input  logic                 pop,
    output tll_pkg::lex_entry_t  head,
    output tll_pkg::lex_q_stat_t stat
);

    localparam int PW = (tll_pkg::QUEUE_DEPTH > 1) ? $clog2(tll_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(tll_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(tll_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(tll_pkg::QUEUE_DEPTH);

    tll_pkg::lex_entry_t ent_reg [tll_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign stat.full      = (count_reg == CNT_FULL);
    assign stat.not_empty = (count_reg != '0);
    assign head           = ent_reg[rd_ptr_reg];

    assign do_push = push.valid && !stat.full;
    assign do_pop  = pop && stat.not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : (wr_ptr_reg + PW'(1));
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : (rd_ptr_reg + PW'(1));
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// File: rtl/tll_back.sv
module tll_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tll_pkg::lex_entry_t  head,
    input  tll_pkg::lex_q_stat_t q_stat,
    output logic                 pop,
    lex_token_if.source          tokens
);

    logic              valid_reg;
    logic              phase_reg;
    tll_pkg::lex_tok_t tok_reg;
    logic [15:0]       line_reg;
    logic              last_reg;

    logic              load;
    logic              last;
    tll_pkg::lex_tok_t tok_sel;

    assign load    = q_stat.not_empty && (!valid_reg || tokens.ready);
    assign tok_sel = phase_reg ? head.t1 : head.t0;
    assign last    = phase_reg || !head.two;
    assign pop     = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            phase_reg <= !last;
        end
        else if (tokens.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= tok_sel;
            line_reg <= head.line;
            last_reg <= last;
        end
    end

    assign tokens.valid         = valid_reg;
    assign tokens.token_kind    = tok_reg.kind;
    assign tokens.keyword_index = tok_reg.kw_index;
    assign tokens.first_char    = tok_reg.first_char;
    assign tokens.second_char   = tok_reg.second_char;
    assign tokens.token_length  = tok_reg.length;
    assign tokens.line_number   = line_reg;
    assign tokens.error_cause   = tok_reg.cause;
    assign tokens.last_of_item  = last_reg;

endmodule

// File: rtl/tll_checker.sv
module tll_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  token_kind,
    input logic [3:0]  keyword_index,
    input logic [7:0]  first_char,
    input logic [7:0]  second_char,
    input logic [5:0]  token_length,
    input logic [15:0] line_number,
    input logic [1:0]  error_cause,
    input logic        last_of_item
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({token_kind, keyword_index, first_char, second_char,
                     token_length, line_number, error_cause, last_of_item}))
        else $error("token changed while stalled");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (token_length != 6'd0) && (line_number != 16'd0))
        else $error("zero length or line");

    a_kw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind != tll_pkg::KIND_KEYWORD) |-> (keyword_index == 4'd0))
        else $error("keyword index on non-keyword");

    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (second_char != 8'h00) |->
            (token_kind == tll_pkg::KIND_DELIM) && (token_length == 6'd2))
        else $error("second char outside two-char delimiter");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ((token_kind == tll_pkg::KIND_ERROR) == (error_cause != tll_pkg::CAUSE_NONE)))
        else $error("error cause mismatch");

endmodule

bind toy_language_lexer_top tll_checker u_tll_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (tokens.valid),
    .out_ready     (tokens.ready),
    .token_kind    (tokens.token_kind),
    .keyword_index (tokens.keyword_index),
    .first_char    (tokens.first_char),
    .second_char   (tokens.second_char),
    .token_length  (tokens.token_length),
    .line_number   (tokens.line_number),
    .error_cause   (tokens.error_cause),
    .last_of_item  (tokens.last_of_item)
);
